// ===== rtl/bb4c_pkg.sv =====
// Types, constants and helpers shared by the 4x4 clamped box blur.
// No dependencies; used by every rtl file via scoped names.
`default_nettype none
package bb4c_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 10;
  localparam int CH_W      = 16;
  localparam int CSUM_W    = 18;
  localparam int HSUM_W    = 20;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  localparam logic [1:0] SLOT0 = 2'd0;
  localparam logic [1:0] SLOT1 = 2'd1;
  localparam logic [1:0] SLOT2 = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               run_last;
  } res_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } colsum_t;

  typedef struct packed {
    logic               has_up;
    logic               last_row;
    logic               has_left;
    logic               last_col;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } meta_t;

  typedef struct packed {
    meta_t         meta;
    colsum_t [3:0] up;
    colsum_t [3:0] dn;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [1:0] mod3_inc(input logic [1:0] s);
    logic [1:0] r;
    unique case (s)
      SLOT0:   r = SLOT1;
      SLOT1:   r = SLOT2;
      default: r = SLOT0;
    endcase
    return r;
  endfunction

  function automatic colsum_t col_sum4(input pixel_t a, input pixel_t b,
                                       input pixel_t c, input pixel_t d);
    colsum_t s;
    s.red   = CSUM_W'(a.red)   + CSUM_W'(b.red)   + CSUM_W'(c.red)   + CSUM_W'(d.red);
    s.green = CSUM_W'(a.green) + CSUM_W'(b.green) + CSUM_W'(c.green) + CSUM_W'(d.green);
    s.blue  = CSUM_W'(a.blue)  + CSUM_W'(b.blue)  + CSUM_W'(c.blue)  + CSUM_W'(d.blue);
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/box_blur_4x4_clamped.sv =====
// Top level of the 4x4 clamped box blur: size registers, front end, queue, sequencer.
// Depends on bb4c_pkg, bb4c_front, bb4c_fifo, bb4c_back.
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+------------------------
//   pixel    | pix_valid, pix_stall, pix        | pix_valid && !pix_stall
//   result   | res_valid, res_stall, res        | res_valid && !res_stall
//   config   | cfg_we, cfg_index, cfg_data      | cfg_we
//
// One pixel per cycle is taken while pix_stall is low; the sequencer gives one result per cycle
// while res_stall is low, and a pixel releases up to four results (right column, bottom row).
// The four-entry queue absorbs those bursts; pix_stall rises only when it is full.
// The first result of a releasing pixel passes the a and b stage registers, queue, work and res registers.
// Synchronous reset clears counters, queue and valids; line buffers are not cleared.
`default_nettype none
module box_blur_4x4_clamped #(
  parameter int MAX_WIDTH  = bb4c_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb4c_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pix_valid,
  output logic                                pix_stall,
  input  wire bb4c_pkg::pix_in_t              pix,
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output bb4c_pkg::res_t                      res,
  input  wire logic                           cfg_we,
  input  wire logic [bb4c_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bb4c_pkg::CFG_W-1:0]     cfg_data
);

  logic [bb4c_pkg::CFG_W-1:0] image_width, image_height;
  bb4c_pkg::qstat_t qstat;
  bb4c_pkg::qent_t  push_data, pop_data;
  logic             push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb4c_pkg::IMAGE_WIDTH_RST;
      image_height <= bb4c_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bb4c_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bb4c_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bb4c_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pix          (pix),
    .image_width  (image_width),
    .image_height (image_height),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  bb4c_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  bb4c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_data  (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

// ===== rtl/bb4c_front.sv =====
// Front end: raster counters, three line buffers, vertical column sums and
// horizontal tap registers. Pushes one queue entry per pixel that releases results.
// Depends on bb4c_pkg.
`default_nettype none
module bb4c_front #(
  parameter int MAX_WIDTH  = bb4c_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb4c_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pix_valid,
  output logic                            pix_stall,
  input  wire bb4c_pkg::pix_in_t          pix,
  input  wire logic [bb4c_pkg::CFG_W-1:0] image_width,
  input  wire logic [bb4c_pkg::CFG_W-1:0] image_height,
  input  wire bb4c_pkg::qstat_t           qstat,
  output logic                            push,
  output bb4c_pkg::qent_t                 push_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);

  logic adv, accept;
  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  logic [CW-1:0] col_cnt, col_cnt_next, col_cur;
  logic [RW-1:0] row_cnt, row_cnt_next, row_cur;
  logic [1:0]    slot, slot_next, slot_cur;

  bb4c_pkg::pixel_t px;
  bb4c_pkg::pixel_t rd [3];
  bb4c_pkg::meta_t  cur_meta;

  logic             a_valid, a_first, a_ge1, a_ge2, a_ge3;
  logic [1:0]       a_slot;
  bb4c_pkg::pixel_t a_px;
  bb4c_pkg::meta_t  a_meta;
  logic             a_emits;

  bb4c_pkg::pixel_t p1, p2, p3, d1, d2, d3;
  bb4c_pkg::colsum_t v_up, v_dn;
  bb4c_pkg::colsum_t [3:0] up, dn;

  logic            b_valid;
  bb4c_pkg::meta_t b_meta;

  assign adv       = !qstat.full;
  assign pix_stall = qstat.full;
  assign accept    = pix_valid && adv;

  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = EH'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(image_height);
    end
  end

  // position of this pixel, then of the next one
  always_comb begin : count_logic
    int unsigned ct, rt;
    logic [1:0]  st;
    ct = 32'(col_cnt);
    rt = 32'(row_cnt);
    st = slot;
    if (ct >= 32'(eff_w)) begin
      ct = 0;
      rt = rt + 1;
      st = bb4c_pkg::mod3_inc(st);
    end
    if (rt >= 32'(eff_h)) begin
      rt = 0;
      st = bb4c_pkg::SLOT0;
    end
    col_cur  = CW'(ct);
    row_cur  = RW'(rt);
    slot_cur = st;
    ct = ct + 1;
    if (ct >= 32'(eff_w)) begin
      ct = 0;
      rt = rt + 1;
      st = bb4c_pkg::mod3_inc(st);
      if (rt >= 32'(eff_h)) begin
        rt = 0;
        st = bb4c_pkg::SLOT0;
      end
    end
    col_cnt_next = CW'(ct);
    row_cnt_next = RW'(rt);
    slot_next    = st;
  end

  assign px.red   = pix.red_in;
  assign px.green = pix.green_in;
  assign px.blue  = pix.blue_in;

  always_comb begin
    cur_meta.has_up   = (row_cur != '0);
    cur_meta.last_row = (32'(row_cur) == 32'(eff_h) - 1);
    cur_meta.has_left = (col_cur != '0);
    cur_meta.last_col = (32'(col_cur) == 32'(eff_w) - 1);
    cur_meta.col      = bb4c_pkg::COORD_W'(32'(col_cur));
    cur_meta.row      = bb4c_pkg::COORD_W'(32'(row_cur));
  end

  // line buffers, one per row mod 3; read-first so the row three above is seen
  for (genvar s = 0; s < 3; s++) begin : g_line
    bb4c_pkg::pixel_t mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (accept) begin
        rd[s] <= mem[col_cur];
        if (slot_cur == 2'(s)) begin
          mem[col_cur] <= px;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      slot    <= bb4c_pkg::SLOT0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= accept;
      b_valid <= a_valid && a_emits;
      if (accept) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
        slot    <= slot_next;
      end
    end
  end

  assign a_emits = (a_meta.has_up || a_meta.last_row) && (a_meta.has_left || a_meta.last_col);

  // rows above the frame clamp to row 0; on row 0 that is the pixel itself
  always_comb begin
    unique case (a_slot)
      bb4c_pkg::SLOT0: begin p1 = rd[2]; p2 = rd[1]; p3 = rd[0]; end
      bb4c_pkg::SLOT1: begin p1 = rd[0]; p2 = rd[2]; p3 = rd[1]; end
      bb4c_pkg::SLOT2: begin p1 = rd[1]; p2 = rd[0]; p3 = rd[2]; end
      default:         begin p1 = rd[0]; p2 = rd[0]; p3 = rd[0]; end
    endcase
    d1   = a_ge1 ? p1 : a_px;
    d2   = a_ge2 ? p2 : d1;
    d3   = a_ge3 ? p3 : d2;
    v_up = bb4c_pkg::col_sum4(d3, d2, d1, a_px);
    v_dn = bb4c_pkg::col_sum4(d2, d1, a_px, a_px);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px    <= px;
      a_slot  <= slot_cur;
      a_first <= (col_cur == '0);
      a_ge1   <= (32'(row_cur) >= 1);
      a_ge2   <= (32'(row_cur) >= 2);
      a_ge3   <= (32'(row_cur) >= 3);
      a_meta  <= cur_meta;
      if (a_valid) begin
        b_meta <= a_meta;
        if (a_first) begin
          up <= {4{v_up}};
          dn <= {4{v_dn}};
        end else begin
          up <= {up[2:0], v_up};
          dn <= {dn[2:0], v_dn};
        end
      end
    end
  end

  assign push           = adv && b_valid;
  assign push_data.meta = b_meta;
  assign push_data.up   = up;
  assign push_data.dn   = dn;

endmodule
`default_nettype wire

// ===== rtl/bb4c_fifo.sv =====
// Short queue of window entries between front end and result sequencer.
// Depends on bb4c_pkg.
`default_nettype none
module bb4c_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bb4c_pkg::qent_t  push_data,
  input  wire logic             pop,
  output bb4c_pkg::qent_t       pop_data,
  output bb4c_pkg::qstat_t      qstat
);

  localparam int PW = $clog2(bb4c_pkg::QUEUE_DEPTH);

  bb4c_pkg::qent_t store [bb4c_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign qstat.full  = (32'(count) == bb4c_pkg::QUEUE_DEPTH);
  assign qstat.empty = (count == '0);
  assign pop_data    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bb4c_back.sv =====
// Result sequencer: walks the one to four outputs of a queue entry, forms the
// horizontal sums and holds the result in the output register. Depends on bb4c_pkg.
`default_nettype none
module bb4c_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bb4c_pkg::qstat_t qstat,
  input  wire bb4c_pkg::qent_t  pop_data,
  output logic                  pop,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output bb4c_pkg::res_t        res
);

  bb4c_pkg::qent_t work;
  logic            work_valid, row_dn, col_rt;
  logic            can_col, can_row, is_last, emit, load;

  bb4c_pkg::colsum_t [3:0] t;
  logic [bb4c_pkg::HSUM_W-1:0] sr, sg, sb;
  bb4c_pkg::res_t  result;

  assign can_col = !col_rt && work.meta.last_col;
  assign can_row = !row_dn && work.meta.last_row;
  assign is_last = !can_col && !can_row;
  assign emit    = work_valid && (!res_valid || !res_stall);
  assign load    = (!work_valid || (emit && is_last)) && !qstat.empty;
  assign pop     = load;

  // right-edge window repeats the last column
  always_comb begin
    t = row_dn ? work.dn : work.up;
    if (col_rt) begin
      sr = 20'(t[2].red) + 20'(t[1].red) + (20'(t[0].red) << 1);
      sg = 20'(t[2].green) + 20'(t[1].green) + (20'(t[0].green) << 1);
      sb = 20'(t[2].blue) + 20'(t[1].blue) + (20'(t[0].blue) << 1);
    end else begin
      sr = 20'(t[3].red) + 20'(t[2].red) + 20'(t[1].red) + 20'(t[0].red);
      sg = 20'(t[3].green) + 20'(t[2].green) + 20'(t[1].green) + 20'(t[0].green);
      sb = 20'(t[3].blue) + 20'(t[2].blue) + 20'(t[1].blue) + 20'(t[0].blue);
    end
    result.red_out   = sr[bb4c_pkg::HSUM_W-1:4];
    result.green_out = sg[bb4c_pkg::HSUM_W-1:4];
    result.blue_out  = sb[bb4c_pkg::HSUM_W-1:4];
    result.out_col   = col_rt ? work.meta.col : bb4c_pkg::COORD_W'(work.meta.col - 1'b1);
    result.out_row   = row_dn ? work.meta.row : bb4c_pkg::COORD_W'(work.meta.row - 1'b1);
    result.run_last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      res_valid  <= 1'b0;
      row_dn     <= 1'b0;
      col_rt     <= 1'b0;
    end else begin
      if (!res_valid || !res_stall) begin
        res_valid <= emit;
      end
      if (load) begin
        work_valid <= 1'b1;
        row_dn     <= !pop_data.meta.has_up;
        col_rt     <= !pop_data.meta.has_left;
      end else begin
        if (emit && is_last) begin
          work_valid <= 1'b0;
        end
        if (emit && can_col) begin
          col_rt <= 1'b1;
        end else if (emit && can_row) begin
          row_dn <= 1'b1;
          col_rt <= !work.meta.has_left;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= pop_data;
    end
    if (emit) begin
      res <= result;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bb4c_checker.sv =====
// Port-level checks for box_blur_4x4_clamped, attached by bind.
// Depends on bb4c_pkg.
`default_nettype none
module bb4c_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           pix_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire bb4c_pkg::res_t res
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid && !pix_stall)
    else $error("not idle after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // a run continues without a gap once a non-final result transfers
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !res.run_last |=> res_valid)
    else $error("run broken");

endmodule

bind box_blur_4x4_clamped bb4c_checker u_bb4c_checker (.*);
`default_nettype wire
